// File: src/lgwb_pkg.sv
// Types and constants shared by the LED group wave and blink sequencer modules.
package lgwb_pkg;

	localparam int SIZE_SLOTS = 12;
	localparam int SIZE_W     = 3;
	localparam int CFG_W      = SIZE_SLOTS * SIZE_W;
	localparam int OUT_DEVS   = 5;
	localparam int WAVE_BASE  = 11;
	localparam int PERIOD_MAX = 10;

	localparam logic [7:0] MODE_OFF   = 8'd0;
	localparam logic [7:0] MODE_WAVE  = 8'd1;
	localparam logic [7:0] MODE_BLINK = 8'd2;

	localparam logic [1:0] CODE_OFF     = 2'd0;
	localparam logic [1:0] CODE_WAVE    = 2'd1;
	localparam logic [1:0] CODE_WARN    = 2'd2;
	localparam logic [1:0] CODE_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [3:0] group;
		logic [7:0] mode;
		logic [7:0] speed;
		logic [7:0] blink_period;
	} req_t;

	typedef struct packed {
		logic [3:0] out_group;
		logic [1:0] code_dev0;
		logic [1:0] code_dev1;
		logic [1:0] code_dev2;
		logic [1:0] code_dev3;
		logic [1:0] code_dev4;
		logic [4:0] send_mask;
	} res_t;

	// Animation state of one group.
	typedef struct packed {
		logic [3:0] wave_ticks;
		logic [2:0] wave_position;
		logic       wave_lighting;
		logic [3:0] blink_ticks;
		logic       blink_on;
	} anim_t;

endpackage

// File: src/lgwb_in_reg.sv
// Input register stage that holds one request until the update logic takes it.
module lgwb_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  lgwb_pkg::req_t req,
	output logic          req_stall,
	input  logic          take,
	output logic          valid_s1,
	output lgwb_pkg::req_t req_s1
);
	import lgwb_pkg::*;

	logic load;

	// The stage is blocked only while it holds a request that is not taken this cycle.
	assign req_stall = valid_s1 && !take;
	assign load      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_s1 <= req;
		end
	end

endmodule

// File: src/lgwb_step.sv
// Update logic: next animation state, device codes and change mask for one request.
module lgwb_step #(
	parameter int GROUP_COUNT       = 12,
	parameter int DEVICES_PER_GROUP = 5
) (
	input  lgwb_pkg::req_t                   req,
	input  logic [lgwb_pkg::CFG_W-1:0]       group_sizes,
	input  lgwb_pkg::anim_t                  anim_cur,
	input  logic [2*DEVICES_PER_GROUP-1:0]   sent_cur,
	output logic                             wr_en,
	output lgwb_pkg::anim_t                  anim_nxt,
	output logic [2*DEVICES_PER_GROUP-1:0]   sent_nxt,
	output lgwb_pkg::res_t                   res
);
	import lgwb_pkg::*;

	localparam logic [3:0] DEV_MAX = 4'(DEVICES_PER_GROUP);

	logic                         in_range;
	logic [SIZE_W-1:0]            raw_size;
	logic [3:0]                   n;
	logic                         active;
	logic                         is_wave;
	logic                         is_blink;
	logic [7:0]                   spd;
	logic [3:0]                   delay;
	logic [4:0]                   wt;
	logic [3:0]                   wp;
	logic [7:0]                   per_raw;
	logic [3:0]                   per;
	logic [4:0]                   bt;
	logic [1:0]                   dev_code [DEVICES_PER_GROUP];
	logic [DEVICES_PER_GROUP-1:0] dev_mask;
	logic [2*OUT_DEVS-1:0]        out_codes;

	// Display code of slot j under the updated animation state.
	function automatic logic [1:0] slot_code(input int j, input logic [7:0] m,
			input anim_t a);
		logic lit;
		lit = a.wave_lighting ? (4'(j) <= {1'b0, a.wave_position})
		                      : (4'(j) >  {1'b0, a.wave_position});
		if (m == MODE_WAVE) begin
			return lit ? CODE_WAVE : CODE_OFF;
		end else if (m == MODE_BLINK) begin
			return a.blink_on ? CODE_WARN : CODE_OFF;
		end
		return CODE_OFF;
	endfunction

	always_comb begin
		in_range = {1'b0, req.group} < 5'(GROUP_COUNT);
		raw_size = '0;
		for (int k = 0; k < SIZE_SLOTS; k++) begin
			if (req.group == 4'(k)) begin
				raw_size = group_sizes[k*SIZE_W +: SIZE_W];
			end
		end
		n        = ({1'b0, raw_size} > DEV_MAX) ? DEV_MAX : {1'b0, raw_size};
		active   = in_range && (n != 4'd0);
		is_wave  = req.mode == MODE_WAVE;
		is_blink = req.mode == MODE_BLINK;
		wr_en    = active;

		// Wave: delay is eleven minus the speed, never below one.
		spd      = (req.speed == 8'd0) ? 8'd1 : req.speed;
		delay    = (spd >= 8'(WAVE_BASE - 1)) ? 4'd1 : 4'(WAVE_BASE - int'(spd));
		wt       = {1'b0, anim_cur.wave_ticks} + 5'd1;
		wp       = {1'b0, anim_cur.wave_position} + 4'd1;
		anim_nxt = anim_cur;
		if (is_wave) begin
			if (wt >= {1'b0, delay}) begin
				anim_nxt.wave_ticks = 4'd0;
				if (wp >= n) begin
					anim_nxt.wave_position = 3'd0;
					anim_nxt.wave_lighting = !anim_cur.wave_lighting;
				end else begin
					anim_nxt.wave_position = wp[2:0];
				end
			end else begin
				anim_nxt.wave_ticks = wt[3:0];
			end
		end else begin
			anim_nxt.wave_ticks    = 4'd0;
			anim_nxt.wave_position = 3'd0;
			anim_nxt.wave_lighting = 1'b1;
		end

		// Blink: half-period clamped to one through ten.
		per_raw = (req.blink_period == 8'd0) ? 8'd1 : req.blink_period;
		per     = (per_raw > 8'(PERIOD_MAX)) ? 4'(PERIOD_MAX) : per_raw[3:0];
		bt      = {1'b0, anim_cur.blink_ticks} + 5'd1;
		if (is_blink) begin
			if (bt >= {1'b0, per}) begin
				anim_nxt.blink_ticks = 4'd0;
				anim_nxt.blink_on    = !anim_cur.blink_on;
			end else begin
				anim_nxt.blink_ticks = bt[3:0];
			end
		end else begin
			anim_nxt.blink_ticks = 4'd0;
			anim_nxt.blink_on    = 1'b1;
		end

		sent_nxt = sent_cur;
		for (int i = 0; i < DEVICES_PER_GROUP; i++) begin
			dev_code[i] = slot_code(i, req.mode, anim_nxt);
			dev_mask[i] = active && (4'(i) < n) && (sent_cur[2*i +: 2] != dev_code[i]);
			if (dev_mask[i]) begin
				sent_nxt[2*i +: 2] = dev_code[i];
			end
		end

		// Slots at or beyond the group size report off.
		for (int j = 0; j < OUT_DEVS; j++) begin
			out_codes[2*j +: 2] = (active && (4'(j) < n)) ?
				slot_code(j, req.mode, anim_nxt) : CODE_OFF;
		end

		res.out_group = req.group;
		res.code_dev0 = out_codes[1:0];
		res.code_dev1 = out_codes[3:2];
		res.code_dev2 = out_codes[5:4];
		res.code_dev3 = out_codes[7:6];
		res.code_dev4 = out_codes[9:8];
		res.send_mask = 5'(dev_mask);
	end

endmodule

// File: src/led_group_wave_blink_sequencer.sv
// Top level of the LED group wave and blink sequencer: state, result register, config.
//
// Usage:
// Each request on the req channel (req_valid, req_stall, req) is one animation
// tick for one light group: its group, mode, wave speed and blink half-period.
// Every request yields exactly one result on the res channel (res_valid,
// res_stall, res) with the group, the display code of each of the five device
// slots and a mask of the devices whose code differs from the one last sent.
// The device counts of all groups come from one 36-bit register; the user must
// write it through cfg_wr_en and cfg_wr_data only while no request is in flight.
// The block does not enforce this. An accepted request is loaded into the input
// register; when it is taken, the group state and the result register are
// written together, so res_valid rises with that write. Throughput is one
// request per cycle while the receiver does not stall; the per-group state is a
// read-modify-write done when the request is taken, so a request for the same
// group may follow in the very next cycle.
// Reset clears all animation state, sets every remembered code to unknown so
// the first tick of each group sends to all of its devices, and clears the
// group sizes. When the receiver stalls, the result register holds and the
// input register fills; req_stall rises only when both are occupied.
module led_group_wave_blink_sequencer #(
	parameter int GROUP_COUNT       = 12,
	parameter int DEVICES_PER_GROUP = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  lgwb_pkg::req_t             req,
	output logic                       res_valid,
	input  logic                       res_stall,
	output lgwb_pkg::res_t             res,
	input  logic                       cfg_wr_en,
	input  logic [lgwb_pkg::CFG_W-1:0] cfg_wr_data
);
	import lgwb_pkg::*;

	localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int SW = 2 * DEVICES_PER_GROUP;

	logic             valid_s1;
	req_t             req_s1;
	logic             take;
	logic [GW-1:0]    idx_s1;
	logic [CFG_W-1:0] group_sizes_q;
	anim_t            anim_q [GROUP_COUNT];
	logic [SW-1:0]    sent_q [GROUP_COUNT];
	anim_t            anim_cur;
	logic [SW-1:0]    sent_cur;
	logic             wr_en;
	anim_t            anim_nxt;
	logic [SW-1:0]    sent_nxt;
	res_t             res_nxt;
	logic             res_valid_q;
	res_t             res_q;

	lgwb_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.take      (take),
		.valid_s1  (valid_s1),
		.req_s1    (req_s1)
	);

	// The held request moves on whenever the result register is empty or drains.
	assign take   = valid_s1 && (!res_valid_q || !res_stall);
	assign idx_s1 = req_s1.group[GW-1:0];

	// Out-of-range groups read garbage here, but the update logic ignores it.
	assign anim_cur = anim_q[idx_s1];
	assign sent_cur = sent_q[idx_s1];

	lgwb_step #(
		.GROUP_COUNT       (GROUP_COUNT),
		.DEVICES_PER_GROUP (DEVICES_PER_GROUP)
	) u_step (
		.req         (req_s1),
		.group_sizes (group_sizes_q),
		.anim_cur    (anim_cur),
		.sent_cur    (sent_cur),
		.wr_en       (wr_en),
		.anim_nxt    (anim_nxt),
		.sent_nxt    (sent_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_sizes_q <= '0;
		end else if (cfg_wr_en) begin
			group_sizes_q <= cfg_wr_data;
		end
	end

	// Per-group state; remembered codes start as unknown.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < GROUP_COUNT; g++) begin
				anim_q[g] <= '0;
				sent_q[g] <= {DEVICES_PER_GROUP{CODE_UNKNOWN}};
			end
		end else if (take && wr_en) begin
			anim_q[idx_s1] <= anim_nxt;
			sent_q[idx_s1] <= sent_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_take_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> res_valid_q)
		else $error("request taken but no result registered");

	a_stall_needs_held_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && res_valid_q && res_stall)
		else $error("request stalled without a full pipeline");

	a_no_unknown_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.code_dev0 != CODE_UNKNOWN) && (res_q.code_dev1 != CODE_UNKNOWN)
			&& (res_q.code_dev2 != CODE_UNKNOWN) && (res_q.code_dev3 != CODE_UNKNOWN)
			&& (res_q.code_dev4 != CODE_UNKNOWN))
		else $error("unknown code sent to a device");

	a_bad_group_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && ({1'b0, res_q.out_group} >= 5'(GROUP_COUNT))
			|-> (res_q.send_mask == 5'd0))
		else $error("out-of-range group produced a send mask");

endmodule

// File: bench/led_group_wave_blink_sequencer_test.sv
// Self-checking testbench for the LED group wave and blink sequencer.
module led_group_wave_blink_sequencer_test;

	import lgwb_pkg::*;

	localparam int GROUPS      = 12;
	localparam int DEVS        = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 80;

	// Tracks the animation state of every group and predicts the frame that each
	// accepted request produces. Frames wait in order until the block sends them.
	class wave_blink_tracker;
		logic [CFG_W-1:0] group_sizes;
		anim_t            anim [GROUPS];
		logic [1:0]       sent [GROUPS][DEVS];
		res_t             frames_due [$];
		int               errors;

		function new();
			group_sizes = '0;
			errors = 0;
			for (int g = 0; g < GROUPS; g++) begin
				anim[g] = '0;
				for (int d = 0; d < DEVS; d++) sent[g][d] = CODE_UNKNOWN;
			end
		endfunction

		function void report(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endfunction

		function void note_tick(req_t r);
			res_t        f;
			anim_t       a;
			logic [1:0]  codes [DEVS];
			int unsigned n, spd, delay, per, t, p;
			bit          lit;
			f = '0;
			f.out_group = r.group;
			for (int d = 0; d < DEVS; d++) codes[d] = CODE_OFF;
			n = 0;
			if (r.group < GROUPS) begin
				n = 32'(group_sizes[3*r.group +: 3]);
				if (n > DEVS) n = DEVS;
			end
			if (n != 0) begin
				a = anim[r.group];
				if (r.mode == MODE_WAVE) begin
					spd = (r.speed == 0) ? 1 : 32'(r.speed);
					delay = (spd >= WAVE_BASE - 1) ? 1 : WAVE_BASE - spd;
					t = a.wave_ticks + 1;
					if (t >= delay) begin
						p = a.wave_position + 1;
						t = 0;
						// The position also wraps when a shrunk group left it past the end.
						if (p >= n) begin
							p = 0;
							a.wave_lighting = ~a.wave_lighting;
						end
						a.wave_position = 3'(p);
					end
					a.wave_ticks = 4'(t);
				end else begin
					a.wave_ticks = '0;
					a.wave_position = '0;
					a.wave_lighting = 1'b1;
				end
				if (r.mode == MODE_BLINK) begin
					per = (r.blink_period == 0) ? 1 : 32'(r.blink_period);
					if (per > PERIOD_MAX) per = PERIOD_MAX;
					t = a.blink_ticks + 1;
					if (t >= per) begin
						t = 0;
						a.blink_on = ~a.blink_on;
					end
					a.blink_ticks = 4'(t);
				end else begin
					a.blink_ticks = '0;
					a.blink_on = 1'b1;
				end
				anim[r.group] = a;
				for (int i = 0; i < n; i++) begin
					if (r.mode == MODE_WAVE) begin
						lit = a.wave_lighting ? (i <= a.wave_position) : (i > a.wave_position);
						codes[i] = lit ? CODE_WAVE : CODE_OFF;
					end else if (r.mode == MODE_BLINK) begin
						codes[i] = a.blink_on ? CODE_WARN : CODE_OFF;
					end
					if (sent[r.group][i] != codes[i]) begin
						sent[r.group][i] = codes[i];
						f.send_mask[i] = 1'b1;
					end
				end
			end
			f.code_dev0 = codes[0];
			f.code_dev1 = codes[1];
			f.code_dev2 = codes[2];
			f.code_dev3 = codes[3];
			f.code_dev4 = codes[4];
			frames_due.push_back(f);
		endfunction

		function void compare_field(string name, res_t want, logic [7:0] got_v,
				logic [7:0] want_v);
			if (got_v !== want_v)
				report($sformatf("group %0d %s got %0d expected %0d", want.out_group, name,
					got_v, want_v));
		endfunction

		function void check_frame(res_t got);
			res_t want;
			if (frames_due.size() == 0) begin
				report($sformatf("frame for group %0d with no request waiting", got.out_group));
				return;
			end
			want = frames_due.pop_front();
			compare_field("out_group", want, 8'(got.out_group), 8'(want.out_group));
			compare_field("code_dev0", want, 8'(got.code_dev0), 8'(want.code_dev0));
			compare_field("code_dev1", want, 8'(got.code_dev1), 8'(want.code_dev1));
			compare_field("code_dev2", want, 8'(got.code_dev2), 8'(want.code_dev2));
			compare_field("code_dev3", want, 8'(got.code_dev3), 8'(want.code_dev3));
			compare_field("code_dev4", want, 8'(got.code_dev4), 8'(want.code_dev4));
			compare_field("send_mask", want, 8'(got.send_mask), 8'(want.send_mask));
		endfunction
	endclass

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             req_valid   = 1'b0;
	logic             req_stall;
	req_t             req         = '0;
	logic             res_valid;
	logic             res_stall   = 1'b0;
	res_t             res;
	logic             cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;

	wave_blink_tracker board = new();

	// Idle percentages of the two sides; the stimulus changes them per phase.
	int unsigned send_idle_pct = 15;
	int unsigned recv_idle_pct = 55;
	// A long receiver hold-off is asked for by bumping holds_asked; the receiver
	// process alone counts out the cycles of the hold.
	int unsigned holds_asked = 0;
	int unsigned holds_done  = 0;
	int unsigned hold_left   = 0;
	int unsigned cycles      = 0;

	led_group_wave_blink_sequencer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL led_group_wave_blink_sequencer");
			$finish;
		end
	end

	// Receiver: stalls at random, or for a long stretch on demand so that the
	// result register and the input register both fill and the request side
	// sees req_stall.
	always @(posedge clk) begin
		if (holds_done != holds_asked) begin
			holds_done = holds_asked;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Every frame taken from the block is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.check_frame(res);
	end

	// Offers one request, idling first at random, and notes it once accepted.
	// Valid is only lowered while idling, so back-to-back requests keep it high.
	task automatic send_tick(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		board.note_tick(r);
	endtask

	task automatic tick(input int unsigned g, input logic [7:0] mode,
			input logic [7:0] speed, input logic [7:0] period);
		req_t r;
		r.group = 4'(g);
		r.mode = mode;
		r.speed = speed;
		r.blink_period = period;
		send_tick(r);
	endtask

	// Stops offering requests and waits until every predicted frame has arrived,
	// then idles on so that the block is surely idle.
	task automatic wait_quiet();
		req_valid <= 1'b0;
		@(posedge clk);
		while (board.frames_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_group_sizes(input logic [CFG_W-1:0] sizes);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= sizes;
		@(posedge clk);
		board.group_sizes = sizes;
		cfg_wr_en <= 1'b0;
	endtask

	// Random requests, mostly as runs of ticks for one group with fixed settings so
	// that waves and blinks go through full cycles; one choice in ten is a single noise request.
	task automatic run_random(input int unsigned count);
		req_t        r;
		int unsigned left, len;
		left = count;
		while (left > 0) begin
			if ($urandom_range(9) == 0) begin
				r.group = 4'($urandom_range(15));
				r.mode = 8'($urandom);
				r.speed = 8'($urandom);
				r.blink_period = 8'($urandom);
				send_tick(r);
				left--;
			end else begin
				r.group = ($urandom_range(15) == 0) ? 4'($urandom_range(15))
					: 4'($urandom_range(GROUPS-1));
				case ($urandom_range(9))
					0, 1, 2, 3: r.mode = MODE_WAVE;
					4, 5, 6:    r.mode = MODE_BLINK;
					7:          r.mode = MODE_OFF;
					default:    r.mode = 8'($urandom_range(255));
				endcase
				r.speed = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
					: 8'($urandom_range(11));
				r.blink_period = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
					: 8'($urandom_range(11));
				len = $urandom_range(1, 24);
				while (len > 0 && left > 0) begin
					send_tick(r);
					len--;
					left--;
				end
			end
		end
	endtask

	initial begin
		logic [CFG_W-1:0] sizes;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With all sizes still zero after reset, a tick changes nothing.
		tick(0, MODE_WAVE, 5, 5);
		wait_quiet();

		// Mixed sizes: group 8 empty, groups 5 and 6 above the five device slots.
		write_group_sizes({3'd2, 3'd5, 3'd1, 3'd0, 3'd5, 3'd7,
			3'd6, 3'd4, 3'd3, 3'd2, 3'd5, 3'd1});
		tick(0, MODE_OFF, 0, 0);
		tick(0, MODE_OFF, 0, 0);
		tick(12, MODE_WAVE, 1, 1);
		tick(15, MODE_BLINK, 255, 255);
		tick(8, MODE_WAVE, 3, 3);
		tick(6, MODE_BLINK, 0, 0);
		tick(6, MODE_BLINK, 0, 0);
		tick(5, MODE_BLINK, 255, 255);
		tick(5, MODE_BLINK, 255, 255);
		repeat (4) tick(1, MODE_WAVE, 255, 0);
		tick(1, MODE_WAVE, 0, 0);
		tick(3, MODE_WAVE, 10, 7);
		tick(3, MODE_WAVE, 11, 7);
		tick(2, 8'd255, 1, 1);
		tick(2, 8'd3, 1, 1);
		tick(4, MODE_BLINK, 9, 10);
		tick(4, MODE_BLINK, 9, 11);
		tick(11, MODE_WAVE, 1, 2);
		wait_quiet();

		// Shrink group 1 to two devices while its wave index sits at four; the next
		// wave step has to wrap the index and flip the phase.
		write_group_sizes({3'd2, 3'd5, 3'd1, 3'd0, 3'd5, 3'd7,
			3'd6, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1});
		tick(1, MODE_WAVE, 255, 0);
		tick(1, MODE_WAVE, 255, 0);

		// Three phases of idling: sender light and receiver heavy, the reverse, then
		// none. Each phase walks through several size settings, the extremes too.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 55 : 0;
			recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 15 : 0;
			for (int c = 0; c < 6; c++) begin
				wait_quiet();
				case (c)
					1:       sizes = '1;
					2:       sizes = {GROUPS{3'd5}};
					3:       sizes = '0;
					default: sizes = {4'($urandom_range(15)), 32'($urandom)};
				endcase
				write_group_sizes(sizes);
				if (ph == 2 && c == 1)
					holds_asked++;
				run_random((c == 3) ? 10 : 130);
			end
		end

		wait_quiet();
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.frames_due.size() == 0)
			$display("PASS led_group_wave_blink_sequencer");
		else
			$display("FAIL led_group_wave_blink_sequencer");
		$finish;
	end

endmodule
